>>> rtl/vertex_rotate_project_macros.svh
// Assertion macros for the port-level checker.
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex_rotate_project assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex_rotate_project assertion failed");

`endif

>>> rtl/vrp_pkg.sv
`default_nettype none
package vrp_pkg;

  localparam int SCREEN_W = 512;
  localparam int SCREEN_H = 512;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_X        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_X        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_Y        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_Y        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_Z        = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_Z        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_SCALE  = 4'd7;

  // Intermediate widths, sized for any 16-bit input and register pattern
  // and screen sizes up to 4096.
  localparam int NW = 56;          // projection numerator
  localparam int DW = 26;          // offset depth and divisor
  localparam int QW = 17;          // quotient bits kept before saturation
  localparam int AW = NW - 13;     // numerator after the 8192 pre-divide

  localparam int DIV_STAGES = QW;
  localparam int PRE_STAGES = 6;
  localparam int OUT_STAGE  = PRE_STAGES + DIV_STAGES;
  localparam int NSTG       = OUT_STAGE + 1;

endpackage
`default_nettype wire

>>> rtl/vrp_div_lane.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module vrp_div_lane (
  input  logic                              clk_i,
  input  logic [vrp_pkg::DIV_STAGES-1:0]    en_i,
  input  logic [vrp_pkg::AW-1:0]            dividend_i,
  input  logic [vrp_pkg::DW-1:0]            divisor_i,
  input  logic                              neg_i,
  output logic [vrp_pkg::QW-1:0]            quot_o,
  output logic                              ovf_o,
  output logic                              neg_o
);

  localparam int QW = vrp_pkg::QW;
  localparam int DW = vrp_pkg::DW;
  localparam int AW = vrp_pkg::AW;
  localparam int NS = vrp_pkg::DIV_STAGES;

  logic [DW-1:0] rem_q [NS];
  logic [DW-1:0] rem_d [NS];
  logic [QW-1:0] lo_q  [NS];
  logic [QW-1:0] lo_d  [NS];
  logic [QW-1:0] quo_q [NS];
  logic [QW-1:0] quo_d [NS];
  logic [DW-1:0] dv_q  [NS];
  logic [DW-1:0] dv_d  [NS];
  logic          neg_q [NS];
  logic          neg_d [NS];
  logic          ovf_q [NS];
  logic          ovf_d [NS];

  always_comb begin
    logic [DW-1:0] rem_s;
    logic [QW-1:0] lo_s;
    logic [QW-1:0] quo_s;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem_s    = dividend_i[QW+DW-1:QW];
        lo_s     = dividend_i[QW-1:0];
        quo_s    = '0;
        dv_d[k]  = divisor_i;
        neg_d[k] = neg_i;
        // A quotient of 2^QW or more saturates regardless of its low bits.
        ovf_d[k] = (dividend_i[AW-1:QW] >= divisor_i);
      end else begin
        rem_s    = rem_q[k-1];
        lo_s     = lo_q[k-1];
        quo_s    = quo_q[k-1];
        dv_d[k]  = dv_q[k-1];
        neg_d[k] = neg_q[k-1];
        ovf_d[k] = ovf_q[k-1];
      end
      trial    = {rem_s, lo_s[QW-1]};
      ge       = (trial >= {1'b0, dv_d[k]});
      rem_d[k] = ge ? DW'(trial - {1'b0, dv_d[k]}) : trial[DW-1:0];
      lo_d[k]  = {lo_s[QW-2:0], 1'b0};
      quo_d[k] = {quo_s[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        quo_q[k] <= quo_d[k];
        dv_q[k]  <= dv_d[k];
        neg_q[k] <= neg_d[k];
        ovf_q[k] <= ovf_d[k];
      end
    end
  end

  assign quot_o = quo_q[NS-1];
  assign ovf_o  = ovf_q[NS-1];
  assign neg_o  = neg_q[NS-1];

endmodule
`default_nettype wire

>>> rtl/vertex_rotate_project.sv
`default_nettype none
// Rotates one Q2.14 vertex by the Z, Y and X rotation registers, adds the
// depth offset, projects it and maps it to pixel coordinates saturated to
// 16 bits. The pipeline takes one vertex beat per clock unless stalled
// and has 24 register stages: three rotation stages, one depth and focal
// stage, two numerator stages, seventeen stages of bit-serial restoring
// division (one quotient bit per stage) and the output register. The
// accepting edge loads the first stage; the beat then moves on through
// each stage in turn, and out_valid_o is high while it sits in the output
// register. Each stage only holds when the stage after it is full and
// stalled, so empty slots are filled even while a result waits at the
// output. A depth of exactly zero is replaced by 1.0 before the divide
// and raises depth_zero_o.
// Configuration writes are single-cycle and are meant to happen while the
// pipeline is empty; indexes beyond the eight registers are ignored.
module vertex_rotate_project (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [15:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             vertex_x_i,
  input  logic signed [15:0]             vertex_y_i,
  input  logic signed [15:0]             vertex_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             screen_x_o,
  output logic signed [15:0]             screen_y_o,
  output logic                           depth_zero_o
);

  localparam int NW   = vrp_pkg::NW;
  localparam int DW   = vrp_pkg::DW;
  localparam int AW   = vrp_pkg::AW;
  localparam int QW   = vrp_pkg::QW;
  localparam int NSTG = vrp_pkg::NSTG;
  localparam int PRE  = vrp_pkg::PRE_STAGES;
  localparam int OUTS = vrp_pkg::OUT_STAGE;

  // Configuration registers.
  logic signed [15:0] cx_q, sx_q, cy_q, sy_q, cz_q, sz_q;
  logic        [15:0] doff_q, focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= -16'sd16384;
      sx_q    <= '0;
      cy_q    <= 16'sd16384;
      sy_q    <= '0;
      cz_q    <= 16'sd16384;
      sz_q    <= '0;
      doff_q  <= 16'd12288;
      focal_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vrp_pkg::CFG_COS_X:        cx_q    <= cfg_wdata_i;
        vrp_pkg::CFG_SIN_X:        sx_q    <= cfg_wdata_i;
        vrp_pkg::CFG_COS_Y:        cy_q    <= cfg_wdata_i;
        vrp_pkg::CFG_SIN_Y:        sy_q    <= cfg_wdata_i;
        vrp_pkg::CFG_COS_Z:        cz_q    <= cfg_wdata_i;
        vrp_pkg::CFG_SIN_Z:        sz_q    <= cfg_wdata_i;
        vrp_pkg::CFG_DEPTH_OFFSET: doff_q  <= cfg_wdata_i;
        vrp_pkg::CFG_FOCAL_SCALE:  focal_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance enables. A stage loads when it
  // is empty or when the stage after it loads too.
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  // Stage 1: Z rotation. Each output is a sum or difference of two Q.28 products
  // rounded to Q.14 by adding one half and shifting arithmetically.
  logic signed [31:0] m1a, m1b, m1c, m1d;
  logic signed [32:0] t1x, t1y;
  logic signed [18:0] s1_x_q, s1_y_q;
  logic signed [15:0] s1_z_q;

  assign m1a = vertex_x_i * cz_q;
  assign m1b = vertex_y_i * sz_q;
  assign m1c = vertex_y_i * cz_q;
  assign m1d = vertex_x_i * sz_q;
  assign t1x = 33'(m1a) + 33'(m1b) + 33'sd8192;
  assign t1y = 33'(m1c) - 33'(m1d) + 33'sd8192;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_x_q <= t1x[32:14];
      s1_y_q <= t1y[32:14];
      s1_z_q <= vertex_z_i;
    end
  end

  // Stage 2: Y rotation.
  logic signed [34:0] m2a, m2c;
  logic signed [31:0] m2b, m2d;
  logic signed [35:0] t2x, t2z;
  logic signed [21:0] s2_x_q, s2_z_q;
  logic signed [18:0] s2_y_q;

  assign m2a = s1_x_q * cy_q;
  assign m2b = s1_z_q * sy_q;
  assign m2c = s1_x_q * sy_q;
  assign m2d = s1_z_q * cy_q;
  assign t2x = 36'(m2a) - 36'(m2b) + 36'sd8192;
  assign t2z = 36'(m2c) + 36'(m2d) + 36'sd8192;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_x_q <= t2x[35:14];
      s2_z_q <= t2z[35:14];
      s2_y_q <= s1_y_q;
    end
  end

  // Stage 3: X rotation.
  logic signed [34:0] m3a, m3d;
  logic signed [37:0] m3b, m3c;
  logic signed [38:0] t3y, t3z;
  logic signed [24:0] s3_y_q, s3_z_q;
  logic signed [21:0] s3_x_q;

  assign m3a = s2_y_q * cx_q;
  assign m3b = s2_z_q * sx_q;
  assign m3c = s2_z_q * cx_q;
  assign m3d = s2_y_q * sx_q;
  assign t3y = 39'(m3a) + 39'(m3b) + 39'sd8192;
  assign t3z = 39'(m3c) - 39'(m3d) + 39'sd8192;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_y_q <= t3y[38:14];
      s3_z_q <= t3z[38:14];
      s3_x_q <= s2_x_q;
    end
  end

  // Stage 4: depth offset (Q4.12 to Q.14 is a shift by two), zero-depth
  // substitution and the focal products.
  logic signed [DW-1:0] zd_raw, zd_sel;
  logic                 zd_zero;
  logic signed [38:0]   xf_d;
  logic signed [41:0]   yf_d;
  logic signed [DW-1:0] s4_zd_q;
  logic                 s4_zero_q;
  logic signed [38:0]   s4_xf_q;
  logic signed [41:0]   s4_yf_q;

  assign zd_raw  = DW'(s3_z_q) + $signed({8'b0, doff_q, 2'b00});
  assign zd_zero = (zd_raw == '0);
  assign zd_sel  = zd_zero ? DW'(16384) : zd_raw;
  assign xf_d    = s3_x_q * $signed({1'b0, focal_q});
  assign yf_d    = s3_y_q * $signed({1'b0, focal_q});

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_zd_q   <= zd_sel;
      s4_zero_q <= zd_zero;
      s4_xf_q   <= xf_d;
      s4_yf_q   <= yf_d;
    end
  end

  // Stage 5: numerators of the combined projection and viewport mapping.
  logic signed [NW-1:0] zd_ext, nx_d, ny_d;
  logic signed [NW-1:0] s5_nx_q, s5_ny_q;
  logic signed [DW-1:0] s5_zd_q;
  logic                 s5_zero_q;

  assign zd_ext = NW'(s4_zd_q) <<< 12;
  assign nx_d   = NW'(s4_xf_q) * NW'(vrp_pkg::SCREEN_H) + NW'(vrp_pkg::SCREEN_W) * zd_ext;
  assign ny_d   = NW'(s4_yf_q) * NW'(vrp_pkg::SCREEN_H) + NW'(vrp_pkg::SCREEN_H) * zd_ext;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_nx_q   <= nx_d;
      s5_ny_q   <= ny_d;
      s5_zd_q   <= s4_zd_q;
      s5_zero_q <= s4_zero_q;
    end
  end

  // Stage 6: magnitudes and signs. Truncating by 8192 first and then by
  // the depth gives the same quotient as one truncating divide.
  logic [NW-1:0] nx_abs, ny_abs;
  logic [DW-1:0] zd_abs;
  logic [AW-1:0] s6_ax_q, s6_ay_q;
  logic [DW-1:0] s6_d_q;
  logic          s6_negx_q, s6_negy_q;

  assign nx_abs = s5_nx_q[NW-1] ? NW'(-s5_nx_q) : NW'(s5_nx_q);
  assign ny_abs = s5_ny_q[NW-1] ? NW'(-s5_ny_q) : NW'(s5_ny_q);
  assign zd_abs = s5_zd_q[DW-1] ? DW'(-s5_zd_q) : DW'(s5_zd_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_ax_q   <= nx_abs[NW-1:13];
      s6_ay_q   <= ny_abs[NW-1:13];
      s6_d_q    <= zd_abs;
      s6_negx_q <= s5_nx_q[NW-1] ^ s5_zd_q[DW-1];
      s6_negy_q <= s5_ny_q[NW-1] ^ s5_zd_q[DW-1];
    end
  end

  logic s5_zero_q_d6;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_zero_q_d6 <= s5_zero_q;
    end
  end

  // The zero-depth flag rides alongside the divider stages.
  logic zero_pipe_q [vrp_pkg::DIV_STAGES];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < vrp_pkg::DIV_STAGES; k++) begin
      if (en[PRE+k]) begin
        zero_pipe_q[k] <= (k == 0) ? s5_zero_q_d6 : zero_pipe_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  logic [QW-1:0] qx, qy;
  logic          ovfx, ovfy, negx, negy;

  vrp_div_lane u_div_x (
    .clk_i      (clk_i),
    .en_i       (en[PRE +: vrp_pkg::DIV_STAGES]),
    .dividend_i (s6_ax_q),
    .divisor_i  (s6_d_q),
    .neg_i      (s6_negx_q),
    .quot_o     (qx),
    .ovf_o      (ovfx),
    .neg_o      (negx)
  );

  vrp_div_lane u_div_y (
    .clk_i      (clk_i),
    .en_i       (en[PRE +: vrp_pkg::DIV_STAGES]),
    .dividend_i (s6_ay_q),
    .divisor_i  (s6_d_q),
    .neg_i      (s6_negy_q),
    .quot_o     (qy),
    .ovf_o      (ovfy),
    .neg_o      (negy)
  );

  // Output stage: apply the sign and saturate to 16 bits.
  function automatic logic [15:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                        input logic neg);
    logic [15:0] r;
    if (ovf) begin
      r = neg ? 16'h8000 : 16'h7FFF;
    end else if (neg) begin
      r = (q > QW'(32768)) ? 16'h8000 : 16'(QW'(0) - q);
    end else begin
      r = (q > QW'(32767)) ? 16'h7FFF : q[15:0];
    end
    return r;
  endfunction

  logic [15:0] sx_out_q, sy_out_q;
  logic        zero_out_q;

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) begin
      sx_out_q   <= sat_q(qx, ovfx, negx);
      sy_out_q   <= sat_q(qy, ovfy, negy);
      zero_out_q <= zero_pipe_q[vrp_pkg::DIV_STAGES-1];
    end
  end

  assign out_valid_o  = v_q[OUTS];
  assign screen_x_o   = sx_out_q;
  assign screen_y_o   = sy_out_q;
  assign depth_zero_o = zero_out_q;

endmodule
`default_nettype wire

>>> rtl/vrp_checker.sv
`default_nettype none
`include "vertex_rotate_project_macros.svh"
// Port-level checks for vertex_rotate_project.
module vrp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [vrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [15:0]                   cfg_wdata_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic signed [15:0]            vertex_x_i,
  input wire logic signed [15:0]            vertex_y_i,
  input wire logic signed [15:0]            vertex_z_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [15:0]            screen_x_o,
  input wire logic signed [15:0]            screen_y_o,
  input wire logic                          depth_zero_o
);

  // A stalled result beat holds its payload.
  `VRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(screen_x_o) && $stable(screen_y_o) && $stable(depth_zero_o))

  // With the output free to move, the whole pipeline moves and in_ready_o is high.
  `VRP_ASSERT_NOW(a_ready_flow, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)

  // Leaving reset, the pipeline is empty and ready.
  `VRP_ASSERT_NOW(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), !out_valid_o && in_ready_o)

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);
`default_nettype wire

>>> bench/tb_vertex_rotate_project.sv
`default_nettype none
module tb_vertex_rotate_project;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [vrp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [15:0] screen_x_o, screen_y_o;
  logic depth_zero_o;

  vertex_rotate_project dut (.*);

  // One predicted screen point per accepted vertex beat.
  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               dz;
  } screen_pt_t;

  screen_pt_t pending_pts[$];

  // Shadow copy of the rotation and projection registers.
  logic signed [15:0] rot_cx, rot_sx, rot_cy, rot_sy, rot_cz, rot_sz;
  logic [15:0] depth_off, focal;

  int err_cnt;
  int beats_sent;
  int points_seen;
  int zero_depth_seen;
  int sat_seen;
  bit idle_en;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("vertex_rotate_project verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s at %0t", msg, $time);
    err_cnt++;
  endtask

  // Rounds a Q.28 sum to Q.14: floor((v + 2^13) / 2^14). The arithmetic
  // shift of a signed value is a floor division.
  function automatic longint q14_round(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Computes where a vertex lands on the screen with the current registers.
  function automatic screen_pt_t project_vertex(input logic signed [15:0] vx,
                                                input logic signed [15:0] vy,
                                                input logic signed [15:0] vz);
    longint x, y, z, t1, t2, zd, den, nx, ny;
    screen_pt_t pt;
    x = vx; y = vy; z = vz;
    t1 = q14_round(x * rot_cz + y * rot_sz);
    t2 = q14_round(-x * rot_sz + y * rot_cz);
    x = t1; y = t2;
    t1 = q14_round(x * rot_cy - z * rot_sy);
    t2 = q14_round(x * rot_sy + z * rot_cy);
    x = t1; z = t2;
    t1 = q14_round(y * rot_cx + z * rot_sx);
    t2 = q14_round(-y * rot_sx + z * rot_cx);
    y = t1; z = t2;
    zd = z + longint'(depth_off) * 4;
    pt.dz = (zd == 0);
    if (pt.dz) zd = 16384;
    den = 2 * 4096 * zd;
    // SystemVerilog division truncates toward zero, as the block does.
    nx = x * longint'(focal) * vrp_pkg::SCREEN_H + longint'(vrp_pkg::SCREEN_W) * zd * 4096;
    ny = y * longint'(focal) * vrp_pkg::SCREEN_H + longint'(vrp_pkg::SCREEN_H) * zd * 4096;
    pt.sx = 16'(clamp16(nx / den));
    pt.sy = 16'(clamp16(ny / den));
    return pt;
  endfunction

  // Writes one register and mirrors it into the shadow copy.
  task automatic write_reg(input logic [vrp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      vrp_pkg::CFG_COS_X:        rot_cx = val;
      vrp_pkg::CFG_SIN_X:        rot_sx = val;
      vrp_pkg::CFG_COS_Y:        rot_cy = val;
      vrp_pkg::CFG_SIN_Y:        rot_sy = val;
      vrp_pkg::CFG_COS_Z:        rot_cz = val;
      vrp_pkg::CFG_SIN_Z:        rot_sz = val;
      vrp_pkg::CFG_DEPTH_OFFSET: depth_off = val;
      vrp_pkg::CFG_FOCAL_SCALE:  focal = val;
      default: ;
    endcase
  endtask

  task automatic write_angles(input logic [15:0] cx, sx, cy, sy, cz, sz,
                              input logic [15:0] doff, fc);
    write_reg(vrp_pkg::CFG_COS_X, cx);
    write_reg(vrp_pkg::CFG_SIN_X, sx);
    write_reg(vrp_pkg::CFG_COS_Y, cy);
    write_reg(vrp_pkg::CFG_SIN_Y, sy);
    write_reg(vrp_pkg::CFG_COS_Z, cz);
    write_reg(vrp_pkg::CFG_SIN_Z, sz);
    write_reg(vrp_pkg::CFG_DEPTH_OFFSET, doff);
    write_reg(vrp_pkg::CFG_FOCAL_SCALE, fc);
  endtask

  // Waits until every predicted point has come back, then lets the
  // pipeline drain before any register changes.
  task automatic drain_pipeline();
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (vrp_pkg::NSTG + 4) @(negedge clk_i);
  endtask

  // Sends one vertex beat, with a random gap in front of it when idling is on.
  task automatic send_vertex(input logic [15:0] vx, vy, vz);
    while (idle_en && $urandom_range(99) < 27) @(negedge clk_i);
    in_valid_i = 1'b1;
    vertex_x_i = vx;
    vertex_y_i = vy;
    vertex_z_i = vz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_pts.push_back(project_vertex(vx, vy, vz));
    beats_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver ready, dropped at random with a 27 percent chance while idling is on.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !(idle_en && $urandom_range(99) < 27);
  end

  // Checks each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    screen_pt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      points_seen++;
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected result beat");
      end else begin
        want = pending_pts.pop_front();
        if (depth_zero_o) zero_depth_seen++;
        if (screen_x_o == 16'sh7fff || screen_x_o == -16'sh8000) sat_seen++;
        if (screen_x_o !== want.sx)
          report_mismatch($sformatf("screen_x: got %0d expected %0d", screen_x_o, want.sx));
        if (screen_y_o !== want.sy)
          report_mismatch($sformatf("screen_y: got %0d expected %0d", screen_y_o, want.sy));
        if (depth_zero_o !== want.dz)
          report_mismatch($sformatf("depth_zero: got %0d expected %0d", depth_zero_o,
                                    want.dz));
      end
    end
  end

  function automatic logic [15:0] rand_q14();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Reset values alone: identity Y and Z, X flipped, depth 3.0, focal 1.0.
  task automatic test_reset_view();
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sd16384, -16'sd16384, 16'sd16384);
    send_vertex(-16'sd16384, 16'sd16384, -16'sd16384);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff);
    send_vertex(16'h8000, 16'h7fff, 16'h8000);
    send_vertex(16'hffff, 16'h0001, 16'h5555);
  endtask

  // Zero depth, negative depth and saturation corners.
  task automatic test_depth_cases();
    drain_pipeline();
    write_angles(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                 16'd4096, 16'd4096);
    // z = -1.0 cancels an offset of 1.0 exactly.
    send_vertex(16'sd0, 16'sd0, -16'sd16384);
    send_vertex(16'sd16384, 16'sd16384, -16'sd16384);
    send_vertex(-16'sd16384, -16'sd16384, -16'sd16384);
    // One step either side of zero depth gives a tiny divisor and saturates.
    send_vertex(16'sd16384, -16'sd16384, -16'sd16383);
    send_vertex(16'sd16384, 16'sd16384, -16'sd16385);
    drain_pipeline();
    // Zero offset: depth is z itself, negative depth divides through.
    write_angles(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                 16'd0, 16'hffff);
    send_vertex(16'sd100, 16'sd200, 16'sd0);
    send_vertex(16'sd16384, 16'sd16384, -16'sd1);
    send_vertex(-16'sd16384, 16'sd16384, 16'sd1);
    send_vertex(16'sd8192, -16'sd8192, 16'sd16384);
    drain_pipeline();
    // Largest raw patterns everywhere.
    write_angles(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'hffff, 16'hffff);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    send_vertex(16'h7fff, 16'h8000, 16'h0000);
    drain_pipeline();
    // Out-of-range indexes are ignored by the block and the shadow alike.
    write_reg(4'd8, 16'h1234);
    write_reg(4'd15, 16'hffff);
    send_vertex(16'sd1000, -16'sd2000, 16'sd3000);
  endtask

  // Random vertices under random angle settings, with and without idling.
  task automatic test_random_stream(input int n_phases, input int per_phase);
    for (int p = 0; p < n_phases; p++) begin
      drain_pipeline();
      if (p % 4 == 3)
        write_angles(rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word());
      else
        write_angles(rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                     rand_q14(), 16'($urandom_range(8192, 32768)),
                     16'($urandom_range(1024, 16384)));
      idle_en = (p != 1);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) == 0)
          send_vertex(rand_word(), rand_word(), rand_word());
        else
          send_vertex(rand_q14(), rand_q14(), rand_q14());
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    int guard;
    err_cnt = 0;
    beats_sent = 0;
    points_seen = 0;
    zero_depth_seen = 0;
    sat_seen = 0;
    idle_en = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    vertex_x_i = '0;
    vertex_y_i = '0;
    vertex_z_i = '0;
    out_ready_i = 1'b0;
    rot_cx = -16'sd16384; rot_sx = 16'sd0;
    rot_cy = 16'sd16384;  rot_sy = 16'sd0;
    rot_cz = 16'sd16384;  rot_sz = 16'sd0;
    depth_off = 16'd12288;
    focal = 16'd4096;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_view();
    test_depth_cases();
    test_random_stream(10, 48);

    guard = 0;
    while (pending_pts.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (vrp_pkg::NSTG + 4) @(negedge clk_i);
    if (pending_pts.size() != 0) begin
      report_mismatch($sformatf("%0d predicted points never arrived", pending_pts.size()));
    end

    $display("Sent %0d vertex beats and checked %0d screen points,", beats_sent,
             points_seen);
    $display("%0d with zero depth and %0d saturated in x.", zero_depth_seen, sat_seen);
    if (err_cnt == 0) begin
      $display("vertex_rotate_project verification clean");
    end else begin
      $display("vertex_rotate_project verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
